@@ hdl/mp2s_pkg.sv @@
package mp2s_pkg;

    typedef logic [31:0] t_word;

    // register indexes (word address bits [3:2])
    localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd0;
    localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PLANE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_PLANE_WIDTH   = 2'd3;

    // monotone key: sign-magnitude order of the raw bits
    function automatic t_word f_key(input t_word bits);
        f_key = bits[31] ? ~bits : (bits | 32'h8000_0000);
    endfunction

    // a wins ties
    function automatic t_word f_pick(input t_word a, input t_word b);
        f_pick = (f_key(b) > f_key(a)) ? b : a;
    endfunction

endpackage

@@ hdl/mp2s_line_bank.sv @@
module mp2s_line_bank import mp2s_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mp2s_max_tree.sv @@
module mp2s_max_tree import mp2s_pkg::*; #(
    parameter int N = 8
) (
    input  logic         i_clk,
    input  t_word        i_val [N],
    input  logic [N-1:0] i_en,
    output t_word        o_max
);

    localparam int P = 1 << $clog2(N);

    t_word nd_v [2*P-1];
    logic  nd_e [2*P-1];
    t_word r_max;

    // heap-ordered tree, leaves at P-1..2P-2; masked leaves drop out
    always_comb begin
        for (int j = 0; j < P; j++) begin
            if (j < N) begin
                nd_v[P-1+j] = i_val[j];
                nd_e[P-1+j] = i_en[j];
            end else begin
                nd_v[P-1+j] = '0;
                nd_e[P-1+j] = 1'b0;
            end
        end
        for (int k = P - 2; k >= 0; k--) begin
            if (nd_e[2*k+1] && nd_e[2*k+2]) begin
                nd_v[k] = f_pick(nd_v[2*k+1], nd_v[2*k+2]);
            end else if (nd_e[2*k+1]) begin
                nd_v[k] = nd_v[2*k+1];
            end else begin
                nd_v[k] = nd_v[2*k+2];
            end
            nd_e[k] = nd_e[2*k+1] | nd_e[2*k+2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_max <= nd_v[0];
    end

    assign o_max = r_max;

endmodule

@@ hdl/max_pool_2d_stride1_top.sv @@
// Channel   | Signals                                          | Dir
// ----------+--------------------------------------------------+-----
// sample    | i_sample_valid, o_sample_ready, i_sample          | in
// pooled    | o_pool_valid, i_pool_ready, o_pooled_value,       | out
//           | o_row_end, o_plane_end                            |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,     | APB
//           | pready                                           |
//
// Each sample beat passes through these steps: accept/line-store access, the
// registered memory read into the column tree, window shift, window tree, then
// the output register. The registered line store read and the two registered
// compare trees lie in series on this path.
// The next sample beat is taken while a pooled beat waits in the output
// register; processing stalls only at the output load if it is still full.
// Reset (i_rst_n low, synchronous) clears counters, FSM and output valid and
// loads the register defaults; line stores are not cleared.
module max_pool_2d_stride1_top import mp2s_pkg::*; #(
    parameter int MAX_KERNEL       = 8,
    parameter int MAX_PLANE_WIDTH  = 1024,
    parameter int MAX_PLANE_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        i_sample_valid,
    output logic        o_sample_ready,
    input  logic [31:0] i_sample,
    // pooled stream
    output logic        o_pool_valid,
    input  logic        i_pool_ready,
    output logic [31:0] o_pooled_value,
    output logic        o_row_end,
    output logic        o_plane_end,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // widths
    localparam int KEW = $clog2(MAX_KERNEL + 1);          // effective kernel dim
    localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PWW = $clog2(MAX_PLANE_WIDTH + 1);
    localparam int PHW = $clog2(MAX_PLANE_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_PLANE_WIDTH);
    localparam int RW  = $clog2(MAX_PLANE_HEIGHT);

    // FSM codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_COL  = 3'd2;
    localparam logic [2:0] S_WIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // config registers
    logic [3:0]  r_kh, r_kw;
    logic [10:0] r_ph, r_pw;

    logic [KEW-1:0] kh_eff, kw_eff;
    logic [PHW-1:0] ph_eff;
    logic [PWW-1:0] pw_eff;

    // counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [SW-1:0] r_slot;

    logic [2:0] r_state;

    // per-beat context
    t_word             r_sample;
    logic [MAX_KERNEL-1:0] r_colmask;
    logic [MAX_KERNEL-1:0] r_winmask;
    logic              r_do_col, r_do_out, r_row_end, r_plane_end;

    // column maxima window
    t_word r_win [MAX_KERNEL];

    // output register
    logic  r_out_valid, r_out_row_end, r_out_plane_end;
    t_word r_out_value;

    logic cfg_we, accept, out_load;

    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [SW-1:0] slot_eff;
    logic          col_last, row_last;
    logic [MAX_KERNEL-1:0] colmask, winmask;

    t_word rd_data  [MAX_KERNEL];
    t_word col_vals [MAX_KERNEL+1];
    t_word colmax, winmax;
    logic [MAX_KERNEL:0] col_en;

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_kh == 4'd0)                    kh_eff = KEW'(1);
        else if (32'(r_kh) > MAX_KERNEL)     kh_eff = KEW'(MAX_KERNEL);
        else                                 kh_eff = KEW'(r_kh);
        if (r_kw == 4'd0)                    kw_eff = KEW'(1);
        else if (32'(r_kw) > MAX_KERNEL)     kw_eff = KEW'(MAX_KERNEL);
        else                                 kw_eff = KEW'(r_kw);
        if (r_ph == 11'd0)                   ph_eff = PHW'(1);
        else if (32'(r_ph) > MAX_PLANE_HEIGHT) ph_eff = PHW'(MAX_PLANE_HEIGHT);
        else                                 ph_eff = PHW'(r_ph);
        if (r_pw == 11'd0)                   pw_eff = PWW'(1);
        else if (32'(r_pw) > MAX_PLANE_WIDTH) pw_eff = PWW'(MAX_PLANE_WIDTH);
        else                                 pw_eff = PWW'(r_pw);
    end

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_KERNEL_HEIGHT: prdata = {28'd0, r_kh};
            REG_KERNEL_WIDTH:  prdata = {28'd0, r_kw};
            REG_PLANE_HEIGHT:  prdata = {21'd0, r_ph};
            REG_PLANE_WIDTH:   prdata = {21'd0, r_pw};
            default:           prdata = '0;
        endcase
    end

    assign o_sample_ready = (r_state == S_IDLE);
    assign accept         = i_sample_valid & o_sample_ready;

    // counters stay inside the plane; clamp again in case of odd settings
    always_comb begin
        col_eff  = r_col;
        row_eff  = r_row;
        slot_eff = r_slot;
        if ((PWW+1)'(r_col) >= (PWW+1)'(pw_eff)) col_eff = '0;
        if ((PHW+1)'(r_row) >= (PHW+1)'(ph_eff)) begin
            row_eff  = '0;
            slot_eff = '0;
        end
        col_last = ((PWW+1)'(col_eff) + (PWW+1)'(1)) == (PWW+1)'(pw_eff);
        row_last = ((PHW+1)'(row_eff) + (PHW+1)'(1)) == (PHW+1)'(ph_eff);
    end

    // banks at ring distance 1..kh-1 behind the current row join the column; window slots below kw join the window
    always_comb begin
        for (int b = 0; b < MAX_KERNEL; b++) begin
            logic [SW:0] ring_gap;
            if ((SW+1)'(slot_eff) >= (SW+1)'(b)) begin
                ring_gap = (SW+1)'(slot_eff) - (SW+1)'(b);
            end else begin
                ring_gap = (SW+1)'(slot_eff) + (SW+1)'(MAX_KERNEL) - (SW+1)'(b);
            end
            colmask[b] = (ring_gap != '0)
                         && ((KEW+SW+1)'(ring_gap) < (KEW+SW+1)'(kh_eff));
            winmask[b] = (KEW+SW+1)'(b) < (KEW+SW+1)'(kw_eff);
        end
    end

    // config and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh   <= 4'd2;
            r_kw   <= 4'd2;
            r_ph   <= 11'd1024;
            r_pw   <= 11'd1024;
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_KERNEL_HEIGHT: r_kh <= pwdata[3:0];
                REG_KERNEL_WIDTH:  r_kw <= pwdata[3:0];
                REG_PLANE_HEIGHT:  r_ph <= pwdata[10:0];
                REG_PLANE_WIDTH:   r_pw <= pwdata[10:0];
                default:           r_kh <= r_kh;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row <= row_eff + RW'(1);
                    if (32'(slot_eff) == MAX_KERNEL - 1) r_slot <= '0;
                    else                                 r_slot <= slot_eff + SW'(1);
                end
            end else begin
                r_col <= col_eff + CW'(1);
            end
        end
    end

    // beat context captured at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample    <= i_sample;
            r_colmask   <= colmask;
            r_winmask   <= winmask;
            r_do_col    <= ((KEW+RW+1)'(row_eff) + (KEW+RW+1)'(1))
                           >= (KEW+RW+1)'(kh_eff);
            r_do_out    <= ((KEW+CW+1)'(col_eff) + (KEW+CW+1)'(1))
                           >= (KEW+CW+1)'(kw_eff);
            r_row_end   <= col_last;
            r_plane_end <= col_last & row_last;
        end
    end

    // line store: one bank per ring slot, all read at the same column
    for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
        mp2s_line_bank #(
            .DEPTH (MAX_PLANE_WIDTH),
            .AW    (CW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (accept && (32'(slot_eff) == b)),
            .i_waddr (col_eff),
            .i_wdata (i_sample),
            .i_re    (accept),
            .i_raddr (col_eff),
            .o_rdata (rd_data[b])
        );
        assign col_vals[b+1] = rd_data[b];
        assign col_en[b+1]   = r_colmask[b];
    end

    assign col_vals[0] = r_sample;
    assign col_en[0]   = 1'b1;

    mp2s_max_tree #(.N(MAX_KERNEL + 1)) u_col_tree (
        .i_clk (i_clk),
        .i_val (col_vals),
        .i_en  (col_en),
        .o_max (colmax)
    );

    mp2s_max_tree #(.N(MAX_KERNEL)) u_win_tree (
        .i_clk (i_clk),
        .i_val (r_win),
        .i_en  (r_winmask),
        .o_max (winmax)
    );

    // window shifts only on rows that complete a column
    always_ff @(posedge i_clk) begin
        if (r_state == S_COL && r_do_col) begin
            for (int i = MAX_KERNEL - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0] <= colmax;
        end
    end

    // a pooled beat is loaded once the output register is free
    assign out_load = (r_state == S_OUT) && r_do_col && r_do_out
                      && (!r_out_valid || i_pool_ready);

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_pool_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (accept) r_state <= S_RD;
                S_RD:   r_state <= S_COL;
                S_COL:  r_state <= S_WIN;
                S_WIN:  r_state <= S_OUT;
                S_OUT: begin
                    if (!(r_do_col && r_do_out) || !r_out_valid || i_pool_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_pool_ready)) begin
            r_out_value     <= winmax;
            r_out_row_end   <= r_row_end;
            r_out_plane_end <= r_plane_end;
        end
    end

    assign o_pool_valid   = r_out_valid;
    assign o_pooled_value = r_out_value;
    assign o_row_end      = r_out_row_end;
    assign o_plane_end    = r_out_plane_end;

`ifndef SYNTHESIS
    a_accept_starts_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD))
        else $error("accepted beat did not start a read");

    a_plane_end_row_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pool_valid && o_plane_end) |-> o_row_end)
        else $error("plane end without row end");

    a_col_in_plane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((PWW+1)'(r_col) < (PWW+1)'(pw_eff)))
        else $error("column counter outside plane");

    a_no_own_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_colmask[$past(slot_eff)] == 1'b0))
        else $error("current row bank used in column max");
`endif

endmodule
